>>> rtl/dq2p_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq2p_pkg - shared types and constants of the dq to three-phase modulator
// Widths of the fixed fields, CORDIC constants and the payload that rides
// alongside the CORDIC rotation.
// ----------------------------------------------------------------------------
package dq2p_pkg;

	localparam int SUPPLY_W = 15;
	localparam int VOLT_W   = 16;
	localparam int VOLT2_W  = 17;
	localparam int ANGLE_W  = 16;
	localparam int TURN_W   = 32;
	localparam int CORD_W   = 32;

	localparam int CORDIC_STEPS = 16;
	localparam logic [SUPPLY_W-1:0] SUPPLY_RESET = 15'd3072;
	localparam logic signed [CORD_W-1:0] CORDIC_X0 = 32'sd652032874;
	localparam logic signed [17:0] SQRT3_HALF_Q16 = 18'sd56756;

	// arctangent of 2^-i in 2^-32 turn
	localparam logic signed [CORD_W-1:0] CORDIC_ATAN [CORDIC_STEPS] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
		32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
		32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861
	};

	// payload carried along the rotation chain
	typedef struct packed {
		logic [1:0]                quad;
		logic signed [VOLT2_W-1:0] uq2;
		logic signed [VOLT2_W-1:0] ud2;
	} dq2p_tag_t;

endpackage

>>> rtl/dq_to_three_phase_pwm_duty.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_to_three_phase_pwm_duty - sinusoidal PWM modulator
// Inverse Park (CORDIC sine/cosine) and inverse Clarke with half-supply
// offset; each phase is scaled to a compare value by a pipelined divider.
// ----------------------------------------------------------------------------
//  channel   direction  contents (lowest bits first)
//  s_*       in         quad_voltage, direct_voltage, electric_phase
//  m_*       out        duty_a, duty_b, duty_c
//  cfg_*     in         supply_voltage write
//
//  One transaction per cycle while the output is not stalled; the pipeline is the
//  input register, 16 CORDIC cells, 5 arithmetic stages and one divider cell
//  per duty bit.
//  The whole pipeline advances together; it holds while m_tvalid is high and
//  m_tready is low, and s_tready follows that.
//  arst_n clears all valid bits and loads the supply register with 3072.
// ----------------------------------------------------------------------------
module dq_to_three_phase_pwm_duty #(
	parameter int ANGLE_BITS = 16,
	parameter int DUTY_BITS  = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// quad_voltage, direct_voltage, electric_phase
	input  logic [47:0]                            s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// duty_a, duty_b, duty_c, zero fill
	output logic [((3*DUTY_BITS+7)/8)*8-1:0]       m_tdata,
	input  logic                                   cfg_wen,
	input  logic [dq2p_pkg::SUPPLY_W-1:0]          cfg_wdata
);
	import dq2p_pkg::*;

	localparam int W      = SUPPLY_W + DUTY_BITS;
	localparam int OUT_W  = ((3*DUTY_BITS+7)/8)*8;
	localparam int PROD_W = VOLT2_W + CORD_W;
	localparam int AB_W   = PROD_W - 13;
	localparam int BK_W   = AB_W + 18;
	localparam int U_W    = 56;
	localparam logic [DUTY_BITS-1:0] DMAX = '1;

	logic                     en;
	logic [SUPPLY_W-1:0]      supply_q;
	logic signed [VOLT2_W-1:0] s_sgn;

	// ---- configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supply_q <= SUPPLY_RESET;
		end else if (cfg_wen) begin
			supply_q <= cfg_wdata;
		end
	end

	assign s_sgn    = $signed({2'b00, supply_q});
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// ---- input stage: clamp Uq, reduce angle to quadrant and residue
	logic signed [VOLT2_W-1:0] uq2_raw, ud2_raw, uq2_clp;
	logic [TURN_W-1:0]         turn, turn_rnd;
	logic [1:0]                quad;
	logic [TURN_W-1:0]         resid;

	always_comb begin
		uq2_raw  = {s_tdata[15:0], 1'b0};
		ud2_raw  = {s_tdata[31:16], 1'b0};
		if (uq2_raw > s_sgn) begin
			uq2_clp = s_sgn;
		end else if (uq2_raw < -s_sgn) begin
			uq2_clp = -s_sgn;
		end else begin
			uq2_clp = uq2_raw;
		end
		turn     = TURN_W'({16'd0, s_tdata[47:32]} << (TURN_W - ANGLE_BITS));
		turn_rnd = turn + 32'h2000_0000;
		quad     = turn_rnd[31:30];
		resid    = turn - {quad, 30'd0};
	end

	logic                     v_s1;
	logic signed [CORD_W-1:0] z_s1;
	dq2p_tag_t                tag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1       <= $signed(resid);
			tag_s1.quad <= quad;
			tag_s1.uq2 <= uq2_clp;
			tag_s1.ud2 <= ud2_raw;
		end
	end

	// ---- CORDIC chain
	logic                     c_vld [CORDIC_STEPS+1];
	logic signed [CORD_W-1:0] c_x   [CORDIC_STEPS+1];
	logic signed [CORD_W-1:0] c_y   [CORDIC_STEPS+1];
	logic signed [CORD_W-1:0] c_z   [CORDIC_STEPS+1];
	dq2p_tag_t                c_tag [CORDIC_STEPS+1];

	assign c_vld[0] = v_s1;
	assign c_x[0]   = CORDIC_X0;
	assign c_y[0]   = '0;
	assign c_z[0]   = z_s1;
	assign c_tag[0] = tag_s1;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		dq2p_cordic_cell #(.STEP(i)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.i_vld (c_vld[i]),
			.i_x   (c_x[i]),
			.i_y   (c_y[i]),
			.i_z   (c_z[i]),
			.i_tag (c_tag[i]),
			.o_vld (c_vld[i+1]),
			.o_x   (c_x[i+1]),
			.o_y   (c_y[i+1]),
			.o_z   (c_z[i+1]),
			.o_tag (c_tag[i+1])
		);
	end

	// ---- quadrant fold and Park products
	logic signed [CORD_W-1:0] cos_v, sin_v;
	dq2p_tag_t                tag_e;

	assign tag_e = c_tag[CORDIC_STEPS];

	always_comb begin
		case (tag_e.quad)
			2'd0: begin
				cos_v = c_x[CORDIC_STEPS];
				sin_v = c_y[CORDIC_STEPS];
			end
			2'd1: begin
				cos_v = -c_y[CORDIC_STEPS];
				sin_v = c_x[CORDIC_STEPS];
			end
			2'd2: begin
				cos_v = -c_x[CORDIC_STEPS];
				sin_v = -c_y[CORDIC_STEPS];
			end
			default: begin
				cos_v = c_y[CORDIC_STEPS];
				sin_v = -c_x[CORDIC_STEPS];
			end
		endcase
	end

	logic                     v_s2;
	logic signed [PROD_W-1:0] dc_s2, qs_s2, qc_s2, ds_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= c_vld[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dc_s2 <= tag_e.ud2 * cos_v;
			qs_s2 <= tag_e.uq2 * sin_v;
			qc_s2 <= tag_e.uq2 * cos_v;
			ds_s2 <= tag_e.ud2 * sin_v;
		end
	end

	// ---- alpha and beta, floored to scale 2^17
	logic signed [PROD_W:0] al_full, be_full;
	logic                   v_s3;
	logic signed [AB_W-1:0] al_s3, be_s3;

	always_comb begin
		al_full = (PROD_W+1)'(dc_s2) - (PROD_W+1)'(qs_s2);
		be_full = (PROD_W+1)'(qc_s2) - (PROD_W+1)'(ds_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			al_s3 <= AB_W'(al_full >>> 14);
			be_s3 <= AB_W'(be_full >>> 14);
		end
	end

	// ---- beta times sqrt(3)/2
	logic                   v_s4;
	logic signed [AB_W-1:0] al_s4;
	logic signed [BK_W-1:0] bk_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			al_s4 <= al_s3;
			bk_s4 <= be_s3 * SQRT3_HALF_Q16;
		end
	end

	// ---- inverse Clarke with half-supply offset, scale 2^33
	logic signed [U_W-1:0] al_w, bk_w, off_w, alh_w;
	logic                  v_s5;
	logic signed [U_W-1:0] u_s5 [3];

	always_comb begin
		al_w  = U_W'(al_s4);
		bk_w  = U_W'(bk_s4);
		off_w = $signed({(U_W-SUPPLY_W-32)'(0), supply_q, 32'd0});
		alh_w = al_w <<< 15;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s5[0] <= (al_w <<< 16) + off_w;
			u_s5[1] <= off_w - alh_w + bk_w;
			u_s5[2] <= off_w - alh_w - bk_w;
		end
	end

	// ---- clip and prescale: dividend is floor(u*max / 2^33)
	logic signed [U_W-1:0] full_w;
	logic [W-1:0]          n_top;
	logic [63:0]           scaled [3];
	logic [2:0][W-1:0]     n_d;
	logic                  v_s6;
	logic [2:0][W-1:0]     n_s6;

	always_comb begin
		full_w = $signed({(U_W-SUPPLY_W-33)'(0), supply_q, 33'd0});
		n_top  = W'(supply_q) * W'(DMAX);
		for (int p = 0; p < 3; p++) begin
			scaled[p] = 64'(u_s5[p][47:0]) * 64'(DMAX);
			if (u_s5[p] <= 0) begin
				n_d[p] = '0;
			end else if (u_s5[p] >= full_w) begin
				n_d[p] = n_top;
			end else begin
				n_d[p] = scaled[p][33+W-1:33];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s6 <= n_d;
		end
	end

	// ---- divider chain, one quotient bit per cell
	logic              d_vld [DUTY_BITS+1];
	logic [2:0][W-1:0] d_acc [DUTY_BITS+1];

	assign d_vld[0] = v_s6;
	assign d_acc[0] = n_s6;

	for (genvar k = 0; k < DUTY_BITS; k++) begin : g_div
		dq2p_div_cell #(.DUTY_BITS(DUTY_BITS)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.supply(supply_q),
			.i_vld (d_vld[k]),
			.i_acc (d_acc[k]),
			.o_vld (d_vld[k+1]),
			.o_acc (d_acc[k+1])
		);
	end

	// ---- output; a zero supply forces all duties to zero
	logic [2:0][DUTY_BITS-1:0] duty;

	always_comb begin
		for (int p = 0; p < 3; p++) begin
			duty[p] = (supply_q == '0) ? '0 : d_acc[DUTY_BITS][p][DUTY_BITS-1:0];
		end
	end

	assign m_tvalid = d_vld[DUTY_BITS];
	assign m_tdata  = OUT_W'({duty[2], duty[1], duty[0]});

endmodule

>>> rtl/dq2p_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq2p_cordic_cell - one CORDIC rotation step
// Rotates (x, y) by the arctangent of 2^-STEP towards zero residual angle and
// registers the result with the payload tag.
// ----------------------------------------------------------------------------
module dq2p_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  i_vld,
	input  logic signed [dq2p_pkg::CORD_W-1:0]    i_x,
	input  logic signed [dq2p_pkg::CORD_W-1:0]    i_y,
	input  logic signed [dq2p_pkg::CORD_W-1:0]    i_z,
	input  dq2p_pkg::dq2p_tag_t                   i_tag,
	output logic                                  o_vld,
	output logic signed [dq2p_pkg::CORD_W-1:0]    o_x,
	output logic signed [dq2p_pkg::CORD_W-1:0]    o_y,
	output logic signed [dq2p_pkg::CORD_W-1:0]    o_z,
	output dq2p_pkg::dq2p_tag_t                   o_tag
);
	import dq2p_pkg::*;

	logic signed [CORD_W-1:0] dx, dy;
	logic                     vld_q;
	logic signed [CORD_W-1:0] x_q, y_q, z_q;
	dq2p_tag_t                tag_q;

	// floored shifts of the cross terms
	always_comb begin
		dx = i_y >>> STEP;
		dy = i_x >>> STEP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= i_vld;
		end
	end

	// rotate by the sign of the residual angle
	always_ff @(posedge clk) begin
		if (en) begin
			if (!i_z[CORD_W-1]) begin
				x_q <= i_x - dx;
				y_q <= i_y + dy;
				z_q <= i_z - CORDIC_ATAN[STEP];
			end else begin
				x_q <= i_x + dx;
				y_q <= i_y - dy;
				z_q <= i_z + CORDIC_ATAN[STEP];
			end
			tag_q <= i_tag;
		end
	end

	assign o_vld = vld_q;
	assign o_x   = x_q;
	assign o_y   = y_q;
	assign o_z   = z_q;
	assign o_tag = tag_q;

endmodule

>>> rtl/dq2p_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq2p_div_cell - one restoring division step for all three phases
// Each accumulator holds the partial remainder above the remaining dividend
// and quotient bits; one quotient bit is produced per cell.
// ----------------------------------------------------------------------------
module dq2p_div_cell #(
	parameter int DUTY_BITS = 8
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  logic                                                 en,
	input  logic [dq2p_pkg::SUPPLY_W-1:0]                        supply,
	input  logic                                                 i_vld,
	input  logic [2:0][dq2p_pkg::SUPPLY_W+DUTY_BITS-1:0]         i_acc,
	output logic                                                 o_vld,
	output logic [2:0][dq2p_pkg::SUPPLY_W+DUTY_BITS-1:0]         o_acc
);
	import dq2p_pkg::*;

	localparam int W = SUPPLY_W + DUTY_BITS;

	logic [2:0][SUPPLY_W:0] trial;
	logic [2:0][W-1:0]      acc_d;
	logic                   vld_q;
	logic [2:0][W-1:0]      acc_q;

	// shift in the next dividend bit, subtract the supply if it fits
	always_comb begin
		for (int p = 0; p < 3; p++) begin
			trial[p] = {i_acc[p][W-1:DUTY_BITS], i_acc[p][DUTY_BITS-1]};
			if (trial[p] >= {1'b0, supply}) begin
				acc_d[p] = {SUPPLY_W'(trial[p] - {1'b0, supply}),
					i_acc[p][DUTY_BITS-2:0], 1'b1};
			end else begin
				acc_d[p] = {trial[p][SUPPLY_W-1:0], i_acc[p][DUTY_BITS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= i_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_q <= acc_d;
		end
	end

	assign o_vld = vld_q;
	assign o_acc = acc_q;

endmodule
